FILE: rtl/bma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_pkg
// Shared types, constants and helpers of the binned moment accumulator.
// ----------------------------------------------------------------------------
package bma_pkg;

    localparam int NUM_BINS = 4096;
    localparam int BIN_W    = $clog2(NUM_BINS);

    // Register indexes
    localparam logic [1:0] REG_ORIGIN    = 2'd0;
    localparam logic [1:0] REG_WIDTH     = 2'd1;
    localparam logic [1:0] REG_COUNT     = 2'd2;
    localparam logic [1:0] REG_MINLEN    = 2'd3;

    // Item codes
    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_CLOSE  = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    // Run entry: hits and five sums
    typedef struct packed {
        logic [31:0]        hits;
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        logic signed [63:0] sxx;
        logic signed [63:0] syy;
        logic signed [63:0] sxy;
    } run_t;

    // Total entry: runs and five sums of means
    typedef struct packed {
        logic [31:0]        runs;
        logic signed [63:0] mx;
        logic signed [63:0] my;
        logic signed [63:0] mxx;
        logic signed [63:0] myy;
        logic signed [63:0] mxy;
    } tot_t;

    localparam int RUN_W = $bits(run_t);
    localparam int TOT_W = $bits(tot_t);

    // Saturating signed 64-bit add
    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic [31:0] inc_sat(input logic [31:0] a);
        return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
    endfunction

endpackage

FILE: rtl/bma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_ram
// Single-port synchronous RAM, one write or one read a cycle, registered read.
// ----------------------------------------------------------------------------
module bma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/bma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_div
// Radix-2 restoring divider, signed 64-bit dividend by unsigned 32-bit
// divisor, truncating toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bma_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic [31:0]        divisor,
    output logic               done,
    output logic signed [63:0] quotient
);
    import bma_pkg::*;

    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [32:0] shifted;

    assign shifted = {r_reg[31:0], q_reg[63]};
    assign trial   = {1'b0, shifted} - {2'b00, d_reg};

    // Shift one quotient bit a cycle
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend[63] ? 64'(-dividend) : 64'(dividend);
            r_next   = '0;
            d_next   = divisor;
            neg_next = dividend[63];
            cnt_next = 7'd0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[33])
            begin
                r_next = trial[32:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? 64'(-q_reg) : q_reg;
endmodule

FILE: rtl/binned_moment_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binned_moment_accumulator_unit
// Bins (time, x, y) samples per trajectory and keeps ensemble means per bin.
// ----------------------------------------------------------------------------
// After reset the unit sweeps both bin stores to zero, one bin a cycle, over
// all NUM_BINS (4096) bins with busy high. A sample keeps busy high while
// the bin index comes from a bit-serial 64-by-32 divider and, if the bin is
// in range, for one read-modify-write of the run store. A close walks all
// NUM_BINS bins and clears the run store in the same pass; a touched bin of
// a trajectory that is folded in runs five divisions on the shared divider;
// any other bin is only read and cleared. A read keeps busy high for five
// divisions when the bin holds data and only for its store read when it
// does not; its result appears on done, high for one cycle, in the cycle in
// which busy falls. The receiver cannot stall it.
// ----------------------------------------------------------------------------
module binned_moment_accumulator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic signed [31:0] sample_time,
    input  logic signed [31:0] x_value,
    input  logic signed [31:0] y_value,
    input  logic [11:0]        read_bin,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic               has_data,
    output logic [31:0]        trajectories,
    output logic signed [63:0] bin_start,
    output logic signed [31:0] mean_x,
    output logic [62:0]        mean_x_sq,
    output logic signed [31:0] mean_y,
    output logic [62:0]        mean_y_sq,
    output logic signed [63:0] mean_xy
);
    import bma_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_SDIV   = 11'b00000000100,
        S_SRD    = 11'b00000001000,
        S_SWR    = 11'b00000010000,
        S_CRD    = 11'b00000100000,
        S_CCHK   = 11'b00001000000,
        S_CDIV   = 11'b00010000000,
        S_CWR    = 11'b00100000000,
        S_RRD    = 11'b01000000000,
        S_RDIV   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [31:0] origin_reg;
    logic [30:0] width_reg;
    logic [12:0] count_reg;
    logic [23:0] minlen_reg;
    logic [31:0] runlen_reg;

    // Working registers
    logic [BIN_W-1:0]   addr_reg;
    logic [BIN_W-1:0]   sweep_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [63:0] xx_reg, yy_reg, xy_reg;
    logic               fold_reg;
    logic               rvalid_reg;
    logic [2:0]         k_reg;
    logic signed [63:0] q_reg [5];
    logic [31:0]        div_by_reg;

    // Stores
    logic       run_we, tot_we;
    logic [BIN_W-1:0] ram_addr;
    run_t       run_wdata, run_rdata;
    tot_t       tot_wdata, tot_rdata;

    bma_ram #(.WIDTH(RUN_W), .DEPTH(NUM_BINS)) u_run (
        .clk(clk), .we(run_we), .addr(ram_addr),
        .wdata(run_wdata), .rdata(run_rdata));
    bma_ram #(.WIDTH(TOT_W), .DEPTH(NUM_BINS)) u_tot (
        .clk(clk), .we(tot_we), .addr(ram_addr),
        .wdata(tot_wdata), .rdata(tot_rdata));

    // Shared divider
    logic               div_start, div_done;
    logic signed [63:0] div_a, div_q;
    logic [31:0]        div_b;
    bma_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q));

    logic [31:0] width_eff;
    logic [12:0] used;
    logic signed [32:0] diff;
    assign width_eff = (width_reg == '0) ? 32'd1 : {1'b0, width_reg};
    assign used      = (count_reg > 13'(NUM_BINS)) ? 13'(NUM_BINS) : count_reg;
    assign diff      = {sample_time[31], sample_time} - {origin_reg[31], origin_reg};

    logic accept;
    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // Operand for the k-th division
    logic signed [63:0] num_sel;
    always_comb
    begin
        num_sel = '0;
        if (state_reg == S_RDIV)
        begin
            case (k_reg)
                3'd0: num_sel = tot_rdata.mx;
                3'd1: num_sel = tot_rdata.my;
                3'd2: num_sel = tot_rdata.mxx;
                3'd3: num_sel = tot_rdata.myy;
                default: num_sel = tot_rdata.mxy;
            endcase
        end
        else
        begin
            case (k_reg)
                3'd0: num_sel = run_rdata.sx;
                3'd1: num_sel = run_rdata.sy;
                3'd2: num_sel = run_rdata.sxx;
                3'd3: num_sel = run_rdata.syy;
                default: num_sel = run_rdata.sxy;
            endcase
        end
    end

    // Sequencer
    logic       in_range;
    logic [63:0] bin_q;
    assign bin_q    = div_q;
    assign in_range = !xx_reg[63] && (bin_q < 64'(used));

    always_comb
    begin
        state_next = state_reg;
        run_we     = 1'b0;
        tot_we     = 1'b0;
        ram_addr   = addr_reg;
        run_wdata  = '0;
        tot_wdata  = tot_rdata;
        div_start  = 1'b0;
        div_a      = num_sel;
        div_b      = div_by_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_addr  = sweep_reg;
                run_we    = 1'b1;
                tot_we    = 1'b1;
                tot_wdata = '0;
                if (sweep_reg == BIN_W'(NUM_BINS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                ram_addr = read_bin[BIN_W-1:0];
                if (accept)
                begin
                    if (func == FUNC_SAMPLE)
                    begin
                        div_start  = 1'b1;
                        div_a      = 64'(diff);
                        div_b      = width_eff;
                        state_next = S_SDIV;
                    end
                    else if (func == FUNC_CLOSE)
                        state_next = S_CRD;
                    else if (func == FUNC_READ)
                        state_next = S_RRD;
                end
            end
            S_SDIV:
            begin
                ram_addr = bin_q[BIN_W-1:0];
                if (div_done)
                    state_next = in_range ? S_SRD : S_IDLE;
            end
            S_SRD:
                state_next = S_SWR;
            S_SWR:
            begin
                run_we          = 1'b1;
                run_wdata.hits  = inc_sat(run_rdata.hits);
                run_wdata.sx    = add_sat(run_rdata.sx, 64'(x_reg));
                run_wdata.sy    = add_sat(run_rdata.sy, 64'(y_reg));
                run_wdata.sxx   = add_sat(run_rdata.sxx, xx_reg);
                run_wdata.syy   = add_sat(run_rdata.syy, yy_reg);
                run_wdata.sxy   = add_sat(run_rdata.sxy, xy_reg);
                state_next      = S_IDLE;
            end
            S_CRD:
                state_next = S_CCHK;
            S_CCHK:
            begin
                if (fold_reg && run_rdata.hits != '0)
                begin
                    div_start  = 1'b1;
                    div_a      = run_rdata.sx;
                    div_b      = run_rdata.hits;
                    state_next = S_CDIV;
                end
                else
                    state_next = S_CWR;
            end
            S_CDIV:
            begin
                if (div_done)
                begin
                    if (k_reg == 3'd4)
                        state_next = S_CWR;
                    else
                        div_start = 1'b1;
                end
            end
            S_CWR:
            begin
                run_we = 1'b1;
                if (fold_reg && run_rdata.hits != '0)
                begin
                    tot_we         = 1'b1;
                    tot_wdata.runs = inc_sat(tot_rdata.runs);
                    tot_wdata.mx   = add_sat(tot_rdata.mx, q_reg[0]);
                    tot_wdata.my   = add_sat(tot_rdata.my, q_reg[1]);
                    tot_wdata.mxx  = add_sat(tot_rdata.mxx, q_reg[2]);
                    tot_wdata.myy  = add_sat(tot_rdata.myy, q_reg[3]);
                    tot_wdata.mxy  = add_sat(tot_rdata.mxy, q_reg[4]);
                end
                state_next = (addr_reg == BIN_W'(NUM_BINS - 1)) ? S_IDLE : S_CRD;
            end
            S_RRD:
            begin
                if (tot_rdata.runs == '0)
                    state_next = S_IDLE;
                else
                begin
                    div_start  = 1'b1;
                    div_a      = tot_rdata.mx;
                    div_b      = tot_rdata.runs;
                    state_next = S_RDIV;
                end
            end
            S_RDIV:
            begin
                if (div_done)
                begin
                    if (k_reg == 3'd4)
                        state_next = S_IDLE;
                    else
                        div_start = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg == S_CCHK || state_reg == S_CDIV)
            div_b = (state_reg == S_CCHK) ? run_rdata.hits : div_by_reg;
        if (state_reg == S_CDIV || state_reg == S_RDIV)
        begin
            case (k_reg)
                3'd0: div_a = (state_reg == S_RDIV) ? tot_rdata.my  : run_rdata.sy;
                3'd1: div_a = (state_reg == S_RDIV) ? tot_rdata.mxx : run_rdata.sxx;
                3'd2: div_a = (state_reg == S_RDIV) ? tot_rdata.myy : run_rdata.syy;
                default: div_a = (state_reg == S_RDIV) ? tot_rdata.mxy : run_rdata.sxy;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            sweep_reg  <= '0;
            origin_reg <= '0;
            width_reg  <= 31'd6554;
            count_reg  <= 13'd4096;
            minlen_reg <= 24'd500;
            runlen_reg <= '0;
            k_reg      <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= 1'b0;
            if (state_reg == S_CLEAR)
                sweep_reg <= sweep_reg + 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ORIGIN: origin_reg <= cfg_data;
                    REG_WIDTH:  width_reg  <= cfg_data[30:0];
                    REG_COUNT:  count_reg  <= cfg_data[12:0];
                    REG_MINLEN: minlen_reg <= cfg_data[23:0];
                    default:    ;
                endcase
            end
            if (accept && func == FUNC_SAMPLE)
                runlen_reg <= inc_sat(runlen_reg);
            if (state_reg == S_CWR && state_next == S_IDLE)
                runlen_reg <= '0;
            if (div_start && state_reg != S_CDIV && state_reg != S_RDIV)
                k_reg <= '0;
            else if (div_done && (state_reg == S_CDIV || state_reg == S_RDIV))
                k_reg <= k_reg + 3'd1;
            if (state_reg == S_RRD && tot_rdata.runs == '0)
                rvalid_reg <= 1'b1;
            if (state_reg == S_RDIV && div_done && k_reg == 3'd4)
                rvalid_reg <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept && func == FUNC_SAMPLE)
        begin
            x_reg  <= x_value;
            y_reg  <= y_value;
            xx_reg <= {diff[32], 63'd0};
            yy_reg <= '0;
            xy_reg <= '0;
        end
        if (state_reg == S_SDIV && div_done)
        begin
            xx_reg <= 64'(x_reg) * 64'(x_reg);
            yy_reg <= 64'(y_reg) * 64'(y_reg);
            xy_reg <= 64'(x_reg) * 64'(y_reg);
            addr_reg <= bin_q[BIN_W-1:0];
        end
        if (accept && func == FUNC_CLOSE)
        begin
            addr_reg <= '0;
            fold_reg <= (runlen_reg >= {8'd0, minlen_reg});
        end
        if (accept && func == FUNC_READ)
            addr_reg <= read_bin[BIN_W-1:0];
        if (state_reg == S_CWR)
            addr_reg <= addr_reg + 1'b1;
        if (div_start)
            div_by_reg <= div_b;
        if (div_done && (state_reg == S_CDIV || state_reg == S_RDIV))
            q_reg[k_reg] <= div_q;
    end

    // Result word
    logic signed [63:0] mx_c, my_c;
    logic [43:0]        start_off;
    assign mx_c = q_reg[0];
    assign my_c = q_reg[1];
    assign start_off = 44'(width_eff) * 44'(addr_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RRD)
        begin
            trajectories <= tot_rdata.runs;
            bin_start    <= (tot_rdata.runs == '0) ? '0 :
                            64'(signed'(origin_reg)) + 64'(start_off);
        end
    end

    assign done     = rvalid_reg;
    assign has_data = (trajectories != '0);
    always_comb
    begin
        mean_x = (mx_c > 64'sd2147483647) ? 32'sh7FFF_FFFF :
                 (mx_c < -64'sd2147483648) ? 32'sh8000_0000 : mx_c[31:0];
        mean_y = (my_c > 64'sd2147483647) ? 32'sh7FFF_FFFF :
                 (my_c < -64'sd2147483648) ? 32'sh8000_0000 : my_c[31:0];
        mean_x_sq = q_reg[2][62:0];
        mean_y_sq = q_reg[3][62:0];
        mean_xy   = q_reg[4];
        if (trajectories == '0)
        begin
            mean_x = '0; mean_y = '0; mean_x_sq = '0; mean_y_sq = '0; mean_xy = '0;
        end
    end

`ifndef ASSERT_OFF
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy) else $error("cfg ready while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE) else $error("result while working");
    a_one_we: assert property (@(posedge clk) disable iff (!rst_n)
        tot_we |-> (state_reg == S_CWR || state_reg == S_CLEAR))
        else $error("stray total write");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result held");
`endif
endmodule
